[rtl/core/tcpnr_pkg.sv]
// ----------------------------------------------------------------------------
// tcpnr_pkg
// Shared types, codes and helpers for the NewReno congestion window engine.
// ----------------------------------------------------------------------------
package tcpnr_pkg;

   // field widths
   localparam int unsigned SEQ_W      = 32;
   localparam int unsigned MSS_W      = 16;
   localparam int unsigned CNT_W      = 4;
   localparam int unsigned REQ_DATA_W = 160;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 72;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // event codes
   localparam logic [1:0] OP_OPEN = 2'd0;
   localparam logic [1:0] OP_ACK  = 2'd1;
   localparam logic [1:0] OP_DUP  = 2'd2;
   localparam logic [1:0] OP_RTO  = 2'd3;

   // retransmit request codes
   localparam logic [1:0] RK_NONE    = 2'd0;
   localparam logic [1:0] RK_FAST    = 2'd1;
   localparam logic [1:0] RK_TIMEOUT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MSS       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_THR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIM_TX    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUP_THR   = 2'd3;

   // register reset values
   localparam logic [MSS_W-1:0] MSS_RESET      = 16'd536;
   localparam logic [SEQ_W-1:0] INIT_THR_RESET = 32'd65535;
   localparam logic [CNT_W-1:0] DUP_THR_RESET  = 4'd3;

   // smallest window loaded on open, and dup counter ceiling
   localparam logic [SEQ_W-1:0] INIT_WINDOW_FLOOR = 32'd4380;
   localparam logic [CNT_W-1:0] CNT_MAX           = 4'd15;

   // divider length
   localparam int unsigned      DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd32;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic prep;
      logic div_start;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_free;
   } status_type;

   // add with ceiling at all ones
   function automatic logic [SEQ_W-1:0] sat_add(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
      logic [SEQ_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SEQ_W] ? {SEQ_W{1'b1}} : s[SEQ_W-1:0];
   endfunction

   // a before b in modulo sequence space
   function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return d[SEQ_W-1];
   endfunction

endpackage

[rtl/core/tcpnr_div.sv]
// ----------------------------------------------------------------------------
// tcpnr_div
// Restoring 32 by 32 bit unsigned divider, one quotient bit per cycle.
// A zero divisor gives an all ones quotient.
// ----------------------------------------------------------------------------
module tcpnr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tcpnr_pkg::SEQ_W-1:0] dividend,
   input  logic [tcpnr_pkg::SEQ_W-1:0] divisor,
   output logic [tcpnr_pkg::SEQ_W-1:0] quotient,
   output logic                        last
);

   logic                            busy_ff, busy_in;
   logic [tcpnr_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [tcpnr_pkg::SEQ_W-1:0]     rem_ff, rem_in;
   logic [tcpnr_pkg::SEQ_W-1:0]     quo_ff, quo_in;
   logic [tcpnr_pkg::SEQ_W:0]       shifted;
   logic [tcpnr_pkg::SEQ_W:0]       trial;
   logic                            fits;

   // one shift and trial subtract per step
   always_comb begin
      shifted = {rem_ff, quo_ff[tcpnr_pkg::SEQ_W-1]};
      fits    = shifted >= {1'b0, divisor};
      trial   = shifted - {1'b0, divisor};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = tcpnr_pkg::DIV_STEPS;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != 6'd1;
         rem_in  = fits ? trial[tcpnr_pkg::SEQ_W-1:0] : shifted[tcpnr_pkg::SEQ_W-1:0];
         quo_in  = {quo_ff[tcpnr_pkg::SEQ_W-2:0], fits};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign last     = busy_ff && (cnt_ff == 6'd1);

endmodule

[rtl/core/tcpnr_ctrl.sv]
// ----------------------------------------------------------------------------
// tcpnr_ctrl
// Sequencer for one event: accept, prepare, optional divide, commit.
// ----------------------------------------------------------------------------
module tcpnr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tcpnr_pkg::status_type sts,
   output tcpnr_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PREP = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // no item is taken while reset is held
   assign req_tready = (state_ff == S_IDLE) && !reset;

endmodule

[rtl/core/tcpnr_dp.sv]
// ----------------------------------------------------------------------------
// tcpnr_dp
// Datapath: settings, connection state, event operands, precomputed terms,
// avoidance divider and the result register.
// ----------------------------------------------------------------------------
module tcpnr_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tcpnr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcpnr_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [tcpnr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [tcpnr_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tcpnr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  tcpnr_pkg::cmd_type               cmd,
   output tcpnr_pkg::status_type            sts
);

   localparam int unsigned W = tcpnr_pkg::SEQ_W;

   // settings
   logic [tcpnr_pkg::MSS_W-1:0] mss_ff;
   logic [W-1:0]                init_thr_ff;
   logic                        lim_tx_ff;
   logic [tcpnr_pkg::CNT_W-1:0] dup_thr_ff;

   // connection state
   logic [W-1:0]                win_ff, win_in;
   logic [W-1:0]                thr_ff, thr_in;
   logic [W-1:0]                rp_ff, rp_in;
   logic                        rec_ff, rec_in;
   logic [tcpnr_pkg::CNT_W-1:0] dc_ff, dc_in;

   // event operands
   logic [1:0]   op_ff;
   logic [W-1:0] ack_ff, prev_ff, nxt_ff, mx_ff, peer_ff;
   logic [W-1:0] sq_ff;

   // precomputed terms
   logic [W-1:0] new_thr_ff, lim_ff, defl_ff;
   logic [W-1:0] flight, half, d_ack, d_clip, new_thr_in, lim_in, defl_in;

   // result register
   logic                                 rsp_valid_ff;
   logic [tcpnr_pkg::RSP_DATA_W-1:0]     rsp_data_ff;

   // commit terms
   logic [W-1:0]                mss_w, two_mss, three_mss, quo, q_min1;
   logic [tcpnr_pkg::CNT_W-1:0] dc_inc;
   logic                        full_ack;
   logic [1:0]                  rkind;
   logic                        sdata, sone, rtimer, aerr;
   logic                        div_last;

   assign mss_w     = W'(mss_ff);
   assign two_mss   = W'({mss_ff, 1'b0});
   assign three_mss = two_mss + mss_w;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mss_ff      <= tcpnr_pkg::MSS_RESET;
         init_thr_ff <= tcpnr_pkg::INIT_THR_RESET;
         lim_tx_ff   <= 1'b0;
         dup_thr_ff  <= tcpnr_pkg::DUP_THR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tcpnr_pkg::CSR_MSS:      mss_ff      <= csr_wdata[tcpnr_pkg::MSS_W-1:0];
            tcpnr_pkg::CSR_INIT_THR: init_thr_ff <= csr_wdata[W-1:0];
            tcpnr_pkg::CSR_LIM_TX:   lim_tx_ff   <= csr_wdata[0];
            tcpnr_pkg::CSR_DUP_THR:  dup_thr_ff  <= csr_wdata[tcpnr_pkg::CNT_W-1:0];
         endcase
      end
   end

   // event code, known from reset on
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= tcpnr_pkg::OP_OPEN;
      end else if (cmd.load) begin
         op_ff <= req_tuser;
      end
   end

   // latch the event and square the segment size
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ack_ff  <= req_tdata[31:0];
         prev_ff <= req_tdata[63:32];
         nxt_ff  <= req_tdata[95:64];
         mx_ff   <= req_tdata[127:96];
         peer_ff <= req_tdata[159:128];
         sq_ff   <= mss_ff * mss_ff;
      end
   end

   // flight, halved threshold, recovery limit and partial-ack deflation
   always_comb begin
      flight     = (win_ff < peer_ff) ? win_ff : peer_ff;
      half       = flight >> 1;
      new_thr_in = (half > two_mss) ? half : two_mss;
      lim_in     = tcpnr_pkg::sat_add(flight, mss_w);
      d_ack      = ack_ff - prev_ff;
      d_clip     = (d_ack > mss_w) ? mss_w : d_ack;
      defl_in    = (d_clip > win_ff) ? '0 : win_ff - d_clip;
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         new_thr_ff <= new_thr_in;
         lim_ff     <= lim_in;
         defl_ff    <= defl_in;
      end
   end

   // avoidance increment mss*mss / cwnd
   tcpnr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sq_ff),
      .divisor  (win_ff),
      .quotient (quo),
      .last     (div_last)
   );

   // event update
   always_comb begin
      q_min1   = (quo == '0) ? W'(1) : quo;
      dc_inc   = (dc_ff == tcpnr_pkg::CNT_MAX) ? dc_ff : dc_ff + 1'b1;
      full_ack = rec_ff && !tcpnr_pkg::seq_before(ack_ff, rp_ff);
      win_in   = win_ff;
      thr_in   = thr_ff;
      rp_in    = rp_ff;
      rec_in   = rec_ff;
      dc_in    = dc_ff;
      rkind    = tcpnr_pkg::RK_NONE;
      sdata    = 1'b0;
      sone     = 1'b0;
      rtimer   = 1'b0;
      aerr     = 1'b0;
      unique case (op_ff)
         tcpnr_pkg::OP_OPEN: begin
            thr_in = init_thr_ff;
            win_in = (two_mss > tcpnr_pkg::INIT_WINDOW_FLOOR) ?
                     two_mss : tcpnr_pkg::INIT_WINDOW_FLOOR;
            rp_in  = '0;
            rec_in = 1'b0;
            dc_in  = '0;
         end
         tcpnr_pkg::OP_ACK: begin
            if (full_ack) begin
               win_in = (thr_ff < lim_ff) ? thr_ff : lim_ff;
               rec_in = 1'b0;
               dc_in  = '0;
               sdata  = 1'b1;
            end else if (rec_ff) begin
               if (tcpnr_pkg::seq_before(ack_ff, prev_ff)) begin
                  aerr = 1'b1;
               end else begin
                  win_in = tcpnr_pkg::sat_add(defl_ff, mss_w);
                  rkind  = tcpnr_pkg::RK_FAST;
                  dc_in  = '0;
               end
            end else begin
               win_in = tcpnr_pkg::sat_add(win_ff, (win_ff < thr_ff) ? mss_w : q_min1);
               dc_in  = '0;
               sdata  = 1'b1;
            end
         end
         tcpnr_pkg::OP_DUP: begin
            dc_in = dc_inc;
            if (dc_inc == dup_thr_ff && !rec_ff) begin
               rec_in = 1'b1;
               rp_in  = nxt_ff;
               thr_in = new_thr_ff;
               win_in = tcpnr_pkg::sat_add(new_thr_ff, three_mss);
               rkind  = tcpnr_pkg::RK_FAST;
               rtimer = 1'b1;
            end else if (rec_ff) begin
               win_in = tcpnr_pkg::sat_add(win_ff, mss_w);
            end else if (lim_tx_ff) begin
               sone = 1'b1;
            end
         end
         tcpnr_pkg::OP_RTO: begin
            rp_in  = mx_ff;
            dc_in  = '0;
            rec_in = 1'b0;
            thr_in = new_thr_ff;
            win_in = mss_w;
            rkind  = tcpnr_pkg::RK_TIMEOUT;
            rtimer = 1'b1;
         end
      endcase
   end

   // connection state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
         thr_ff <= '0;
         rp_ff  <= '0;
         rec_ff <= 1'b0;
         dc_ff  <= '0;
      end else if (cmd.commit) begin
         win_ff <= win_in;
         thr_ff <= thr_in;
         rp_ff  <= rp_in;
         rec_ff <= rec_in;
         dc_ff  <= dc_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= {1'b0, aerr, rtimer, sone, sdata, rkind, rec_in, thr_in, win_in};
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

   assign sts.need_div = (op_ff == tcpnr_pkg::OP_ACK) && !rec_ff && !(win_ff < thr_ff);
   assign sts.div_done = div_last;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

endmodule

[rtl/core/tcp_newreno_congestion_window.sv]
// ----------------------------------------------------------------------------
// tcp_newreno_congestion_window
// NewReno congestion window engine for one connection, one result per event.
// ----------------------------------------------------------------------------
// Events (open, new ack, duplicate ack, retransmit timeout) are taken one at a
// time. An event with no division goes through accept, prepare and commit;
// a new ACK in congestion avoidance adds a divide step where the restoring
// divider computes mss*mss/cwnd one quotient bit per cycle. The next event is
// accepted the cycle after a commit, while the previous result may still wait
// in the output register. The user must write settings through the csr port
// only while no event is pending; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tcp_newreno_congestion_window (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [tcpnr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcpnr_pkg::CSR_DATA_W-1:0] csr_wdata,
   // events
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // ack_seq, prev_una, next_seq, max_seq, peer_window
   input  logic [tcpnr_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [tcpnr_pkg::REQ_USER_W-1:0] req_tuser,
   // results
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // cwnd, ssthresh, in_recovery, retransmit_kind, send_data, send_one_new,
   // restart_timer, ack_error, one pad bit
   output logic [tcpnr_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   tcpnr_pkg::cmd_type    cmd;
   tcpnr_pkg::status_type sts;

   // sequencer
   tcpnr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // state and arithmetic
   tcpnr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

[rtl/core/tcpnr_chk.sv]
// ----------------------------------------------------------------------------
// tcpnr_chk
// Port-level checks for the congestion window engine, bound to the top level.
// ----------------------------------------------------------------------------
module tcpnr_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tcpnr_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // result register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one event at a time
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("event accepted while another is in work");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // retransmit kind stays in its code range
   a_rkind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[66:65] <= tcpnr_pkg::RK_TIMEOUT))
      else $error("bad retransmit kind");

   // an ack error carries no requests
   a_aerr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[70]) |-> (rsp_tdata[69:65] == 5'd0))
      else $error("ack error with requests");

endmodule

bind tcp_newreno_congestion_window tcpnr_chk u_chk (.*);

[sim/tcp_newreno_congestion_window_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_newreno_congestion_window_test
// Self-checking bench for the NewReno congestion window engine.
// ----------------------------------------------------------------------------
// A clocked driver sends events from a queue, in random bursts. A clocked
// monitor runs a window model on each accepted event and compares
// every result, field by field, with the oldest prediction. The events come
// first as a directed set (zero window, saturation, wrapped sequence numbers,
// partial, full and bad acks, dup counter ceiling, limited transmit), then as
// random phases of mostly well-formed ack streams under changing settings.
// The result side stalls on its own random pattern, with two long hold-offs.
// ----------------------------------------------------------------------------
module tcp_newreno_congestion_window_test;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned DRAIN_CYCLES  = 40;
   localparam int unsigned HOLDOFF_LEN   = 300;
   localparam int unsigned RANDOM_PHASES = 16;
   localparam int unsigned PHASE_ITEMS   = 100;
   localparam logic [31:0] OPEN_FLOOR    = 32'd4380;
   localparam logic [3:0]  DUP_CEILING   = 4'd15;
   localparam logic [31:0] WRAP_BASE     = 32'hFFFF_F000;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] ack_seq;
      logic [31:0] prev_una;
      logic [31:0] next_seq;
      logic [31:0] max_seq;
      logic [31:0] peer_window;
   } segment_event_type;

   typedef struct packed {
      logic [31:0] cwnd;
      logic [31:0] ssthresh;
      logic        in_recovery;
      logic [1:0]  retransmit_kind;
      logic        send_data;
      logic        send_one_new;
      logic        restart_timer;
      logic        ack_error;
   } window_report_type;

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             csr_we     = 1'b0;
   logic [tcpnr_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [tcpnr_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // ack_seq, prev_una, next_seq, max_seq, peer_window
   logic [tcpnr_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   // op
   logic [tcpnr_pkg::REQ_USER_W-1:0] req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // cwnd, ssthresh, in_recovery, retransmit_kind, send_data, send_one_new,
   // restart_timer, ack_error, pad
   logic [tcpnr_pkg::RSP_DATA_W-1:0] rsp_tdata;

   tcp_newreno_congestion_window u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // settings mirror and window state of the connection
   logic [15:0] cfg_mss;
   logic [31:0] cfg_init_thr;
   logic        cfg_lim_tx;
   logic [3:0]  cfg_dup_thr;
   logic [31:0] cwnd_q;
   logic [31:0] ssthresh_q;
   logic [31:0] rec_point;
   logic        in_rec;
   logic [3:0]  dup_cnt;

   segment_event_type pending_events[$];
   window_report_type expected_reports[$];
   segment_event_type cur_event;
   bit                item_taken;
   bit                holdoff_request;

   int unsigned cycle_count;
   int unsigned fail_count;
   int unsigned queued_total;
   int unsigned settings_count;
   int unsigned checked_count;
   int unsigned op_count[4];
   int unsigned entry_count;
   int unsigned partial_count;
   int unsigned bad_ack_count;
   int unsigned saturated_count;

   // stimulus side view of the sequence space
   logic [31:0] trk_una;
   logic [31:0] trk_nxt;
   logic [31:0] trk_max;
   int unsigned phase_mss;
   int unsigned phase_dup;

   function automatic logic [31:0] add_ceiling(logic [31:0] a, logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // half the flight, at least two segments
   function automatic logic [31:0] reduced_threshold(logic [31:0] peer);
      logic [31:0] flt;
      logic [31:0] two_seg;
      flt     = (cwnd_q < peer) ? cwnd_q : peer;
      two_seg = 32'(cfg_mss) << 1;
      return ((flt >> 1) > two_seg) ? (flt >> 1) : two_seg;
   endfunction

   // advance the window state by one event and build its report
   function automatic window_report_type newreno_update(segment_event_type ev);
      window_report_type rep;
      logic [31:0]       mss_w;
      logic [31:0]       seq_gap;
      logic [31:0]       span;
      logic [31:0]       cap;
      logic [31:0]       quot;
      rep     = '0;
      mss_w   = 32'(cfg_mss);
      seq_gap = ev.ack_seq - rec_point;
      case (ev.op)
         tcpnr_pkg::OP_OPEN: begin
            ssthresh_q = cfg_init_thr;
            cwnd_q     = ((mss_w << 1) > OPEN_FLOOR) ? (mss_w << 1) : OPEN_FLOOR;
            rec_point  = '0;
            in_rec     = 1'b0;
            dup_cnt    = '0;
         end
         tcpnr_pkg::OP_ACK: begin
            if (in_rec && !seq_gap[31]) begin
               // full ack leaves recovery
               cap = add_ceiling((cwnd_q < ev.peer_window) ? cwnd_q : ev.peer_window,
                                 mss_w);
               cwnd_q        = (ssthresh_q < cap) ? ssthresh_q : cap;
               in_rec        = 1'b0;
               dup_cnt       = '0;
               rep.send_data = 1'b1;
            end else if (in_rec) begin
               // partial ack: deflate by the acked amount up to one segment, inflate by one segment
               span = ev.ack_seq - ev.prev_una;
               if (span[31]) begin
                  rep.ack_error = 1'b1;
               end else begin
                  if (span > mss_w) span = mss_w;
                  cwnd_q = add_ceiling((cwnd_q > span) ? cwnd_q - span : 32'd0, mss_w);
                  rep.retransmit_kind = tcpnr_pkg::RK_FAST;
                  dup_cnt = '0;
               end
            end else begin
               if (cwnd_q < ssthresh_q) begin
                  cwnd_q = add_ceiling(cwnd_q, mss_w);
               end else begin
                  quot = (cwnd_q == 0) ? 32'hFFFF_FFFF : (mss_w * mss_w) / cwnd_q;
                  if (quot == 0) quot = 32'd1;
                  cwnd_q = add_ceiling(cwnd_q, quot);
               end
               dup_cnt       = '0;
               rep.send_data = 1'b1;
            end
         end
         tcpnr_pkg::OP_DUP: begin
            if (dup_cnt != DUP_CEILING) dup_cnt = dup_cnt + 4'd1;
            if (dup_cnt == cfg_dup_thr && !in_rec) begin
               in_rec              = 1'b1;
               rec_point           = ev.next_seq;
               ssthresh_q          = reduced_threshold(ev.peer_window);
               cwnd_q              = add_ceiling(ssthresh_q, mss_w * 32'd3);
               rep.retransmit_kind = tcpnr_pkg::RK_FAST;
               rep.restart_timer   = 1'b1;
            end else if (in_rec) begin
               cwnd_q = add_ceiling(cwnd_q, mss_w);
            end else if (cfg_lim_tx) begin
               rep.send_one_new = 1'b1;
            end
         end
         default: begin
            rec_point           = ev.max_seq;
            dup_cnt             = '0;
            in_rec              = 1'b0;
            ssthresh_q          = reduced_threshold(ev.peer_window);
            cwnd_q              = mss_w;
            rep.retransmit_kind = tcpnr_pkg::RK_TIMEOUT;
            rep.restart_timer   = 1'b1;
         end
      endcase
      rep.cwnd        = cwnd_q;
      rep.ssthresh    = ssthresh_q;
      rep.in_recovery = in_rec;
      return rep;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // sender: bursts of random length, random gaps in between
   int unsigned burst_left;
   int unsigned gap_left;

   always @(negedge clock) begin : sender
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || item_taken) begin
         item_taken = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (pending_events.size() != 0) begin
            cur_event = pending_events.pop_front();
            offer     = 1'b1;
            if (burst_left != 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         req_tvalid <= offer;
         if (offer) begin
            req_tdata <= {cur_event.peer_window, cur_event.max_seq, cur_event.next_seq,
                          cur_event.prev_una, cur_event.ack_seq};
            req_tuser <= cur_event.op;
         end
      end
   end

   // receiver: random stall pattern in changing modes, plus two long hold-offs
   int unsigned holdoff_left;
   int unsigned mode_left;
   int unsigned ready_mode;
   int unsigned ready_tick;

   always @(negedge clock) begin : receiver
      logic next_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            holdoff_left    = HOLDOFF_LEN;
         end
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         ready_tick++;
         if (holdoff_left != 0) begin
            holdoff_left--;
            next_ready = 1'b0;
         end else begin
            case (ready_mode)
               0:       next_ready = 1'b1;
               1:       next_ready = ($urandom_range(0, 9) < 7);
               2:       next_ready = ($urandom_range(0, 9) < 3);
               default: next_ready = ((ready_tick % 4) != 3);
            endcase
         end
         rsp_tready <= next_ready;
      end
   end

   // monitor: settings mirror, prediction on accept, compare on result
   always @(posedge clock) begin : monitor
      window_report_type want;
      window_report_type got;
      if (reset) begin
         cfg_mss      = tcpnr_pkg::MSS_RESET;
         cfg_init_thr = tcpnr_pkg::INIT_THR_RESET;
         cfg_lim_tx   = 1'b0;
         cfg_dup_thr  = tcpnr_pkg::DUP_THR_RESET;
         cwnd_q       = '0;
         ssthresh_q   = '0;
         rec_point    = '0;
         in_rec       = 1'b0;
         dup_cnt      = '0;
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_reports.size());
         $display("tcp_newreno_congestion_window_test: FAIL");
         $finish;
      end else if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               tcpnr_pkg::CSR_MSS:      cfg_mss      = csr_wdata[15:0];
               tcpnr_pkg::CSR_INIT_THR: cfg_init_thr = csr_wdata;
               tcpnr_pkg::CSR_LIM_TX:   cfg_lim_tx   = csr_wdata[0];
               tcpnr_pkg::CSR_DUP_THR:  cfg_dup_thr  = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.cwnd            = rsp_tdata[31:0];
            got.ssthresh        = rsp_tdata[63:32];
            got.in_recovery     = rsp_tdata[64];
            got.retransmit_kind = rsp_tdata[66:65];
            got.send_data       = rsp_tdata[67];
            got.send_one_new    = rsp_tdata[68];
            got.restart_timer   = rsp_tdata[69];
            got.ack_error       = rsp_tdata[70];
            if (expected_reports.size() == 0) begin
               $display("%0t ns: result with nothing expected, got %0h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("cwnd", want.cwnd, got.cwnd);
               check_field("ssthresh", want.ssthresh, got.ssthresh);
               check_field("in_recovery", want.in_recovery, got.in_recovery);
               check_field("retransmit_kind", want.retransmit_kind, got.retransmit_kind);
               check_field("send_data", want.send_data, got.send_data);
               check_field("send_one_new", want.send_one_new, got.send_one_new);
               check_field("restart_timer", want.restart_timer, got.restart_timer);
               check_field("ack_error", want.ack_error, got.ack_error);
               checked_count++;
            end
         end
         if (req_tvalid && req_tready) begin
            want = newreno_update(cur_event);
            expected_reports.push_back(want);
            item_taken = 1'b1;
            op_count[cur_event.op]++;
            if (want.retransmit_kind == tcpnr_pkg::RK_FAST) begin
               if (cur_event.op == tcpnr_pkg::OP_DUP) entry_count++;
               else partial_count++;
            end
            if (want.ack_error) bad_ack_count++;
            if (want.cwnd == 32'hFFFF_FFFF) saturated_count++;
         end
      end
   end

   task automatic push_event(logic [1:0] op, logic [31:0] ack, logic [31:0] prev,
                             logic [31:0] nxt, logic [31:0] mx, logic [31:0] peer);
      segment_event_type ev;
      ev.op          = op;
      ev.ack_seq     = ack;
      ev.prev_una    = prev;
      ev.next_seq    = nxt;
      ev.max_seq     = mx;
      ev.peer_window = peer;
      pending_events.push_back(ev);
      queued_total++;
   endtask

   // all four registers, back to back
   task automatic program_csrs(logic [15:0] mss, logic [31:0] init_thr,
                               logic lim_tx, logic [3:0] dup_thr);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= tcpnr_pkg::CSR_MSS;
      csr_wdata <= {16'd0, mss};
      @(negedge clock);
      csr_index <= tcpnr_pkg::CSR_INIT_THR;
      csr_wdata <= init_thr;
      @(negedge clock);
      csr_index <= tcpnr_pkg::CSR_LIM_TX;
      csr_wdata <= {31'd0, lim_tx};
      @(negedge clock);
      csr_index <= tcpnr_pkg::CSR_DUP_THR;
      csr_wdata <= {28'd0, dup_thr};
      @(negedge clock);
      csr_we    <= 1'b0;
      phase_mss = mss;
      phase_dup = dup_thr;
      settings_count++;
   endtask

   // stimulus waits until the block has answered everything
   task automatic wait_idle();
      while (pending_events.size() != 0 || req_tvalid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_peer();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom;
         default: return $urandom_range(1, 32'h0010_0000);
      endcase
   endfunction

   // one step of a plausible ack stream, sometimes noise
   task automatic add_flow_event();
      int unsigned pick;
      int unsigned run;
      logic [31:0] outstanding;
      logic [31:0] adv;
      logic [31:0] peer;
      logic [31:0] diff;
      pick = $urandom_range(0, 99);
      peer = pick_peer();
      if ($urandom_range(0, 2) == 0) begin
         trk_nxt = trk_nxt + $urandom_range(1, 6) * phase_mss;
         diff    = trk_max - trk_nxt;
         if (diff[31]) trk_max = trk_nxt;
      end
      outstanding = trk_nxt - trk_una;
      if (pick < 2) begin
         if ($urandom_range(0, 1) == 0) begin
            trk_una = $urandom;
            trk_nxt = trk_una;
            trk_max = trk_una;
         end
         push_event(tcpnr_pkg::OP_OPEN, trk_una, trk_una, trk_nxt, trk_max, peer);
      end else if (pick < 7) begin
         push_event(tcpnr_pkg::OP_RTO, trk_una, trk_una, trk_nxt, trk_max, peer);
         trk_nxt = trk_una;
      end else if (pick < 40) begin
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18)
                                           : $urandom_range(1, phase_dup + 2);
         repeat (run) push_event(tcpnr_pkg::OP_DUP, trk_una, trk_una, trk_nxt, trk_max, peer);
      end else if (pick < 92) begin
         case ($urandom_range(0, 3))
            0:       adv = outstanding;
            1:       adv = $urandom_range(1, phase_mss);
            2:       adv = $urandom_range(0, outstanding);
            default: adv = outstanding + $urandom_range(0, 4 * phase_mss);
         endcase
         push_event(tcpnr_pkg::OP_ACK, trk_una + adv, trk_una, trk_nxt, trk_max, peer);
         trk_una = trk_una + adv;
         diff    = trk_nxt - trk_una;
         if (diff[31]) trk_nxt = trk_una;
         diff = trk_max - trk_nxt;
         if (diff[31]) trk_max = trk_nxt;
      end else if (pick < 96) begin
         push_event(tcpnr_pkg::OP_ACK, trk_una - $urandom_range(1, 5000), trk_una, trk_nxt,
                    trk_max, peer);
      end else begin
         push_event(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned target;
      logic [15:0] mss;
      logic [31:0] init_thr;
      logic        lim_tx;
      logic [3:0]  dup_thr;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: zero window before open, recovery across the wrap point
      push_event(tcpnr_pkg::OP_ACK, 0, 0, 0, 0, 32'hFFFF_FFFF);
      repeat (4) push_event(tcpnr_pkg::OP_DUP, WRAP_BASE, WRAP_BASE, WRAP_BASE + 20000,
                            WRAP_BASE + 20000, 32'hFFFF_FFFF);
      push_event(tcpnr_pkg::OP_ACK, WRAP_BASE + 300, WRAP_BASE, WRAP_BASE + 20000,
                 WRAP_BASE + 20000, 32'hFFFF_FFFF);
      push_event(tcpnr_pkg::OP_ACK, WRAP_BASE + 5000, WRAP_BASE + 300, WRAP_BASE + 20000,
                 WRAP_BASE + 20000, 32'hFFFF_FFFF);
      push_event(tcpnr_pkg::OP_ACK, WRAP_BASE + 4000, WRAP_BASE + 5000, WRAP_BASE + 20000,
                 WRAP_BASE + 20000, 32'hFFFF_FFFF);
      push_event(tcpnr_pkg::OP_ACK, WRAP_BASE + 20000, WRAP_BASE + 5000, WRAP_BASE + 20000,
                 WRAP_BASE + 20000, 32'd65535);
      push_event(tcpnr_pkg::OP_OPEN, 0, 0, 0, 0, 0);
      push_event(tcpnr_pkg::OP_ACK, 1000, 0, 3000, 3000, 32'd65535);
      push_event(tcpnr_pkg::OP_RTO, 1000, 1000, 3000, 32'hFFFF_FFFF, 32'd0);
      wait_idle();

      // largest segment, zero threshold, dup trigger that never fires
      program_csrs(16'hFFFF, 32'd0, 1'b1, 4'd0);
      push_event(tcpnr_pkg::OP_OPEN, 0, 0, 0, 0, 32'hFFFF_FFFF);
      repeat (16) push_event(tcpnr_pkg::OP_DUP, 0, 0, 5000, 5000, 32'hFFFF_FFFF);
      push_event(tcpnr_pkg::OP_ACK, 1000, 0, 5000, 5000, 32'hFFFF_FFFF);
      wait_idle();

      // enter recovery with a one-byte segment, then deflate with a large one
      program_csrs(16'd1, 32'd65535, 1'b0, 4'd1);
      push_event(tcpnr_pkg::OP_OPEN, 0, 0, 0, 0, 32'hFFFF_FFFF);
      push_event(tcpnr_pkg::OP_DUP, 0, 0, 32'h0010_0000, 32'h0010_0000, 32'hFFFF_FFFF);
      wait_idle();
      program_csrs(16'hFFFF, 32'd65535, 1'b0, 4'd1);
      push_event(tcpnr_pkg::OP_ACK, 60000, 0, 32'h0010_0000, 32'h0010_0000, 32'hFFFF_FFFF);
      wait_idle();

      // random phases, each under its own settings
      trk_una = $urandom;
      trk_nxt = trk_una;
      trk_max = trk_una;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            mss = 16'hFFFF; init_thr = 32'hFFFF_FFFF; lim_tx = 1'b1; dup_thr = 4'd15;
         end else if (phase == 1) begin
            mss = 16'd1; init_thr = 32'd0; lim_tx = 1'b0; dup_thr = 4'd1;
         end else begin
            case ($urandom_range(0, 5))
               0:       mss = 16'd1;
               1:       mss = 16'hFFFF;
               2:       mss = 16'd536;
               3:       mss = 16'd1460;
               default: mss = $urandom_range(1, 65535);
            endcase
            case ($urandom_range(0, 4))
               0:       init_thr = 32'd0;
               1:       init_thr = 32'hFFFF_FFFF;
               2:       init_thr = 32'd65535;
               3:       init_thr = $urandom_range(0, 200000);
               default: init_thr = $urandom;
            endcase
            lim_tx = $urandom_range(0, 1);
            case ($urandom_range(0, 4))
               0:       dup_thr = 4'd1;
               1:       dup_thr = 4'd15;
               2:       dup_thr = 4'd3;
               default: dup_thr = $urandom_range(0, 15);
            endcase
         end
         program_csrs(mss, init_thr, lim_tx, dup_thr);
         push_event(tcpnr_pkg::OP_OPEN, trk_una, trk_una, trk_nxt, trk_max, pick_peer());
         target = queued_total + PHASE_ITEMS;
         while (queued_total < target) add_flow_event();
         if (phase == 3 || phase == 11) begin
            repeat (20) @(posedge clock);
            holdoff_request = 1'b1;
         end
         wait_idle();
      end

      $display("covered %0d opens, %0d new acks, %0d duplicates, %0d timeouts",
               op_count[tcpnr_pkg::OP_OPEN], op_count[tcpnr_pkg::OP_ACK],
               op_count[tcpnr_pkg::OP_DUP], op_count[tcpnr_pkg::OP_RTO]);
      $display("under %0d settings; %0d recovery entries, %0d partial acks, %0d bad acks,",
               settings_count, entry_count, partial_count, bad_ack_count);
      $display("%0d saturated windows, %0d results checked",
               saturated_count, checked_count);
      if (fail_count == 0 && expected_reports.size() == 0) begin
         $display("tcp_newreno_congestion_window_test: PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, expected_reports.size());
         $display("tcp_newreno_congestion_window_test: FAIL");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/tcpnr_pkg.sv
rtl/core/tcpnr_div.sv
rtl/core/tcpnr_ctrl.sv
rtl/core/tcpnr_dp.sv
rtl/core/tcp_newreno_congestion_window.sv
rtl/core/tcpnr_chk.sv
sim/tcp_newreno_congestion_window_test.sv
